/* src/ple_pkg.sv */
// shared types and constants of the positional list engine
package ple_pkg;

   localparam int OP_W   = 3;
   localparam int POS_W  = 6;
   localparam int VAL_W  = 32;
   localparam int ELEM_W = 32;
   localparam int STAT_W = 2;
   localparam int LEN_W  = 7;

   typedef enum logic [OP_W-1:0] {
      OP_APPEND      = 3'd0,
      OP_INSERT      = 3'd1,
      OP_REMOVE_LAST = 3'd2,
      OP_REMOVE_AT   = 3'd3,
      OP_READ        = 3'd4
   } op_type;

   typedef enum logic [STAT_W-1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2,
      ST_RANGE = 2'd3
   } status_type;

   // controller to datapath
   typedef struct packed {
      logic load;     // latch request beat and plan the operation
      logic step;     // issue one store read and advance the pointer
      logic put;      // write the new element into its slot
      logic finish;   // commit count and load the response register
   } ple_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic left_zero;  // no reads left to issue
      logic pend;       // a read is in flight
      logic need_put;   // operation writes a new element
      logic rsp_free;   // response register can take a beat
   } ple_stat_type;

endpackage

/* src/ple_req_if.sv */
// request channel of the positional list engine
interface ple_req_if import ple_pkg::*; ;
   logic              valid;
   logic              ready;
   logic [OP_W-1:0]   operation;
   logic [POS_W-1:0]  position;
   logic [VAL_W-1:0]  value;

   modport source (output valid, output operation, output position, output value,
                   input ready);
   modport sink   (input valid, input operation, input position, input value,
                   output ready);
endinterface

/* src/ple_rsp_if.sv */
// response channel of the positional list engine
interface ple_rsp_if import ple_pkg::*; ;
   logic              valid;
   logic              ready;
   logic [ELEM_W-1:0] element;
   logic [STAT_W-1:0] status;
   logic [LEN_W-1:0]  length;

   modport source (output valid, output element, output status, output length,
                   input ready);
   modport sink   (input valid, input element, input status, input length,
                   output ready);
endinterface

/* src/ple_ctrl.sv */
// sequencing state machine of the positional list engine
module ple_ctrl import ple_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  ple_stat_type stat,
   output ple_cmd_type  cmd
);

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_RUN  = 4'b0010,
      S_PUT  = 4'b0100,
      S_DONE = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_RUN;
            end
         end
         S_RUN: begin
            if (!stat.left_zero) begin
               cmd.step = 1'b1;
            end else if (!stat.pend) begin
               state_in = stat.need_put ? S_PUT : S_DONE;
            end
         end
         S_PUT: begin
            cmd.put  = 1'b1;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (stat.rsp_free) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* src/ple_datapath.sv */
// element store, count, move pipeline and response register
module ple_datapath import ple_pkg::*; #(
   parameter int DEPTH       = 64,
   parameter int VALUE_WIDTH = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  ple_cmd_type       cmd,
   output ple_stat_type      stat,
   input  logic [OP_W-1:0]   req_operation,
   input  logic [POS_W-1:0]  req_position,
   input  logic [VAL_W-1:0]  req_value,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [ELEM_W-1:0] rsp_element,
   output logic [STAT_W-1:0] rsp_status,
   output logic [LEN_W-1:0]  rsp_length
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int SW = (VALUE_WIDTH < VAL_W) ? VALUE_WIDTH : VAL_W;
   localparam int LW = (CW > POS_W) ? CW : POS_W;
   localparam int OW = (CW > LEN_W) ? CW : LEN_W;

   logic [SW-1:0] mem [DEPTH];
   logic [SW-1:0] rdata_ff;

   logic [CW-1:0] count_ff, cnt_next_ff;
   logic [AW-1:0] at_ff, ptr_ff, pend_addr_ff;
   logic [CW-1:0] left_ff;
   logic [SW-1:0] val_ff;
   logic          dir_up_ff, capture_ff, first_ff, put_ff;
   logic          pend_ff, pend_first_ff;
   status_type    status_ff;
   logic [ELEM_W-1:0] elem_ff;

   logic              rsp_valid_ff;
   logic [ELEM_W-1:0] rsp_element_ff;
   logic [STAT_W-1:0] rsp_status_ff;
   logic [LEN_W-1:0]  rsp_length_ff;

   // operation plan from the request beat and the current count
   logic [LW-1:0] pos_ext, cnt_ext;
   logic [AW-1:0] cnt_lo, pos_lo;
   logic          pos_in_range, full, empty;
   logic [AW-1:0] at_in, ptr_in;
   logic [CW-1:0] left_in, cnt_next_in;
   logic          dir_up_in, capture_in, put_in;
   status_type    status_in;

   always_comb begin
      pos_ext      = LW'(req_position);
      cnt_ext      = LW'(count_ff);
      cnt_lo       = count_ff[AW-1:0];
      pos_lo       = pos_ext[AW-1:0];
      pos_in_range = pos_ext < cnt_ext;
      full         = count_ff == CW'(DEPTH);
      empty        = count_ff == '0;
      at_in        = cnt_lo;
      ptr_in       = cnt_lo;
      left_in      = '0;
      cnt_next_in  = count_ff;
      dir_up_in    = 1'b1;
      capture_in   = 1'b0;
      put_in       = 1'b0;
      status_in    = ST_OK;
      unique case (req_operation)
         OP_APPEND, OP_INSERT: begin
            if (full) begin
               status_in = ST_FULL;
            end else begin
               at_in       = (req_operation == OP_INSERT && pos_in_range) ?
                             pos_lo : cnt_lo;
               left_in     = count_ff - CW'(at_in);
               ptr_in      = cnt_lo - 1'b1;
               dir_up_in   = 1'b0;
               put_in      = 1'b1;
               cnt_next_in = count_ff + 1'b1;
            end
         end
         OP_REMOVE_LAST, OP_REMOVE_AT: begin
            if (empty) begin
               status_in = ST_EMPTY;
            end else begin
               at_in       = (req_operation == OP_REMOVE_AT && pos_in_range) ?
                             pos_lo : cnt_lo - 1'b1;
               left_in     = count_ff - CW'(at_in);
               ptr_in      = at_in;
               capture_in  = 1'b1;
               cnt_next_in = count_ff - 1'b1;
            end
         end
         OP_READ: begin
            if (empty) begin
               status_in = ST_EMPTY;
            end else if (!pos_in_range) begin
               status_in = ST_RANGE;
            end else begin
               left_in    = CW'(1);
               ptr_in     = pos_lo;
               capture_in = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   // store write: new element, else the element moved by the pipeline
   logic          pipe_we, mem_we;
   logic [AW-1:0] mem_waddr;
   logic [SW-1:0] mem_wdata;

   always_comb begin
      pipe_we = pend_ff && !(pend_first_ff && capture_ff);
      if (cmd.put) begin
         mem_we    = 1'b1;
         mem_waddr = at_ff;
         mem_wdata = val_ff;
      end else begin
         mem_we    = pipe_we;
         mem_waddr = dir_up_ff ? pend_addr_ff - 1'b1 : pend_addr_ff + 1'b1;
         mem_wdata = rdata_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rdata_ff <= mem[ptr_ff];
   end

   // plan and move pointers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         at_ff       <= at_in;
         ptr_ff      <= ptr_in;
         left_ff     <= left_in;
         cnt_next_ff <= cnt_next_in;
         dir_up_ff   <= dir_up_in;
         capture_ff  <= capture_in;
         put_ff      <= put_in;
         status_ff   <= status_in;
         first_ff    <= 1'b1;
         val_ff      <= SW'(req_value);
      end else if (cmd.step) begin
         ptr_ff   <= dir_up_ff ? ptr_ff + 1'b1 : ptr_ff - 1'b1;
         left_ff  <= left_ff - 1'b1;
         first_ff <= 1'b0;
      end
      pend_addr_ff  <= ptr_ff;
      pend_first_ff <= first_ff;
   end

   // element of a remove or read comes from the first read
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         elem_ff <= '0;
      end else if (pend_ff && pend_first_ff && capture_ff) begin
         elem_ff <= ELEM_W'(rdata_ff);
      end
   end

   logic [OW-1:0] len_wide;
   assign len_wide = OW'(cnt_next_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pend_ff <= cmd.step;
         if (cmd.finish) begin
            count_ff     <= cnt_next_ff;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_element_ff <= elem_ff;
         rsp_status_ff  <= status_ff;
         rsp_length_ff  <= len_wide[LEN_W-1:0];
      end
   end

   assign stat.left_zero = left_ff == '0;
   assign stat.pend      = pend_ff;
   assign stat.need_put  = put_ff;
   assign stat.rsp_free  = !rsp_valid_ff || rsp_ready;

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_element = rsp_element_ff;
   assign rsp_status  = rsp_status_ff;
   assign rsp_length  = rsp_length_ff;

endmodule

/* src/positional_list_engine.sv */
// top level of the positional list engine
//
// Keeps an ordered list of up to DEPTH element handles in a store with one
// read and one write port plus a count, and answers every request beat with
// exactly one response beat (element, status, length after the operation).
// Items are handled one at a time: req ready is high only while the
// sequencer is idle, and an item holds it until its response is loaded;
// its entries pass through the store's one read and one write port, one
// entry per cycle. Append and insert move the entries from the slot on up
// by one, then write the new entry; remove-last and remove-at read the
// removed entry and move those behind it down, with position taken as
// count - 1 for remove-last or a position past the end; read reads one
// entry; a full, empty or out-of-range case and an unused operation code
// move nothing. The response sits in its own register, so a waiting
// response beat does not hold off the next request until that item is
// done. The store is not cleared after reset; only the count is. Handles
// are kept to min(VALUE_WIDTH, 32) bits.
module positional_list_engine import ple_pkg::*; #(
   parameter int DEPTH       = 64,
   parameter int VALUE_WIDTH = 32
) (
   input  logic          clock,
   input  logic          reset,
   ple_req_if.sink       req_bus,
   ple_rsp_if.source     rsp_bus
);

   ple_cmd_type  cmd;
   ple_stat_type stat;

   // state machine: accept, move entries, write new entry, respond
   ple_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // store, count, move pipeline and response register
   ple_datapath #(
      .DEPTH       (DEPTH),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .stat          (stat),
      .req_operation (req_bus.operation),
      .req_position  (req_bus.position),
      .req_value     (req_bus.value),
      .rsp_valid     (rsp_bus.valid),
      .rsp_ready     (rsp_bus.ready),
      .rsp_element   (rsp_bus.element),
      .rsp_status    (rsp_bus.status),
      .rsp_length    (rsp_bus.length)
   );

`ifndef SYNTHESIS
   // one item at a time: an accepted beat closes the request side
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_bus.valid && req_bus.ready |=> !req_bus.ready)
      else $error("request accepted while an item is in progress");

   // failed operations carry no element
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.status != ST_OK |-> rsp_bus.element == '0)
      else $error("non-ok response with nonzero element");

   // empty status only with an empty list
   a_empty_len: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.status == ST_EMPTY |-> rsp_bus.length == '0)
      else $error("empty status with nonzero length");
`endif

endmodule

/* test/positional_list_engine_test.sv */
// self-checking testbench of the positional list engine: queued stimulus, list predictor, checker
module positional_list_engine_test;
   import ple_pkg::*;

   localparam int DEPTH        = 64;
   localparam int RANDOM_ITEMS = 700;
   localparam int IDLE_PCT     = 19;    // percent of cycles a side sits out
   localparam int CALM_FIRST   = 350;   // beats between these two see no idling at all
   localparam int CALM_LAST    = 470;
   localparam int HOLD_AFTER   = 150;   // response beats before the long hold-off
   localparam int HOLD_CYCLES  = 300;
   localparam int DRAIN_CYCLES = 100;   // beyond the slowest item
   // quiet cycles allowed: the long hold-off plus the slowest item, many times over
   localparam int QUIET_LIMIT  = 2000;
   localparam logic [OP_W-1:0] SPARE_OP_LO = 3'd5;
   localparam logic [OP_W-1:0] SPARE_OP_HI = 3'd7;

   typedef struct {
      logic [OP_W-1:0]  operation;
      logic [POS_W-1:0] position;
      logic [VAL_W-1:0] value;
   } list_request_type;

   typedef struct {
      logic [ELEM_W-1:0] element;
      status_type        status;
      logic [LEN_W-1:0]  length;
   } list_answer_type;

   logic clock;
   logic reset;

   ple_req_if req_bus ();
   ple_rsp_if rsp_bus ();

   positional_list_engine #(
      .DEPTH       (DEPTH),
      .VALUE_WIDTH (VAL_W)
   ) dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   // shadow copy of the list, head at index 0
   logic [VAL_W-1:0] shadow_list [DEPTH];
   int unsigned      shadow_len = 0;

   list_request_type pending_requests [$];
   list_answer_type  expected_answers [$];
   list_request_type next_request;
   list_request_type taken_request;
   list_answer_type  taken_answer;
   list_answer_type  oldest_answer;

   int plan_len       = 0;   // fill level as the stimulus planner sees it
   int total_requests = 0;
   int requests_taken = 0;
   int answers_seen   = 0;
   int mismatch_count = 0;
   int quiet_cycles   = 0;
   int hold_left      = 0;
   bit held_once      = 1'b0;

   logic sender_calm;
   logic receiver_calm;
   assign sender_calm   = requests_taken >= CALM_FIRST && requests_taken < CALM_LAST;
   assign receiver_calm = answers_seen >= CALM_FIRST && answers_seen < CALM_LAST;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic report_mismatch(input string what);
      $display("mismatch at response beat %0d: %s", answers_seen, what);
      mismatch_count++;
   endtask

   // queue one request beat and track the fill level it leads to
   task automatic plan_request(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos,
                               input logic [VAL_W-1:0] val);
      list_request_type r;
      r.operation = op;
      r.position  = pos;
      r.value     = val;
      pending_requests.push_back(r);
      total_requests++;
      if ((op == OP_APPEND || op == OP_INSERT) && plan_len < DEPTH)
         plan_len++;
      else if ((op == OP_REMOVE_LAST || op == OP_REMOVE_AT) && plan_len > 0)
         plan_len--;
   endtask

   // apply one request to the shadow list and work out its response beat
   task automatic predict_answer(input list_request_type r, output list_answer_type a);
      int unsigned slot;
      a.element = '0;
      a.status  = ST_OK;
      case (r.operation)
         OP_APPEND, OP_INSERT: begin
            if (shadow_len >= DEPTH) begin
               a.status = ST_FULL;
            end else begin
               // insert past the end falls back to append
               slot = (r.operation == OP_INSERT && r.position < shadow_len) ?
                      r.position : shadow_len;
               for (int i = shadow_len; i > slot; i--)
                  shadow_list[i] = shadow_list[i - 1];
               shadow_list[slot] = r.value;
               shadow_len++;
            end
         end
         OP_REMOVE_LAST, OP_REMOVE_AT: begin
            if (shadow_len == 0) begin
               a.status = ST_EMPTY;
            end else begin
               // remove-at past the end takes the last element
               slot = (r.operation == OP_REMOVE_AT && r.position < shadow_len) ?
                      r.position : shadow_len - 1;
               a.element = shadow_list[slot];
               for (int i = slot; i + 1 < shadow_len; i++)
                  shadow_list[i] = shadow_list[i + 1];
               shadow_len--;
            end
         end
         OP_READ: begin
            if (shadow_len == 0)
               a.status = ST_EMPTY;
            else if (r.position >= shadow_len)
               a.status = ST_RANGE;
            else
               a.element = shadow_list[r.position];
         end
         default: begin
            // spare codes leave everything alone
         end
      endcase
      a.length = LEN_W'(shadow_len);
   endtask

   // request driver: a new beat only once the current one is taken
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (!req_bus.valid || req_bus.ready) begin
         if (pending_requests.size() != 0 &&
             (sender_calm || $urandom_range(99) >= IDLE_PCT)) begin
            next_request = pending_requests.pop_front();
            req_bus.valid     <= 1'b1;
            req_bus.operation <= next_request.operation;
            req_bus.position  <= next_request.position;
            req_bus.value     <= next_request.value;
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // every accepted request beat feeds the predictor
   always @(posedge clock) begin
      if (!reset && req_bus.valid && req_bus.ready) begin
         taken_request.operation = req_bus.operation;
         taken_request.position  = req_bus.position;
         taken_request.value     = req_bus.value;
         predict_answer(taken_request, taken_answer);
         expected_answers.push_back(taken_answer);
         requests_taken <= requests_taken + 1;
      end
   end

   // response receiver: random stalls, one long hold-off to back the block up
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left     <= hold_left - 1;
         rsp_bus.ready <= 1'b0;
      end else if (!held_once && answers_seen >= HOLD_AFTER) begin
         held_once     <= 1'b1;
         hold_left     <= HOLD_CYCLES;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= receiver_calm || $urandom_range(99) >= IDLE_PCT;
      end
   end

   // response checker: oldest expectation against each accepted beat
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         answers_seen <= answers_seen + 1;
         if (expected_answers.size() == 0) begin
            report_mismatch("response beat with nothing expected");
         end else begin
            oldest_answer = expected_answers.pop_front();
            if (rsp_bus.element !== oldest_answer.element)
               report_mismatch($sformatf("element %h, expected %h",
                                         rsp_bus.element, oldest_answer.element));
            if (rsp_bus.status !== oldest_answer.status)
               report_mismatch($sformatf("status %0d, expected %s",
                                         rsp_bus.status, oldest_answer.status.name()));
            if (rsp_bus.length !== oldest_answer.length)
               report_mismatch($sformatf("length %0d, expected %0d",
                                         rsp_bus.length, oldest_answer.length));
         end
      end
   end

   // cycles with no beat on either channel
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
   end

   initial begin
      wait (quiet_cycles >= QUIET_LIMIT);
      $display("watchdog: no beat for %0d cycles", QUIET_LIMIT);
      $display("Some tests failed");
      $finish;
   end

   initial begin
      logic [OP_W-1:0]  op;
      logic [POS_W-1:0] pos;
      logic [VAL_W-1:0] val;
      int               roll;
      bit               coin;
      bit               growing;

      reset             = 1'b1;
      req_bus.valid     = 1'b0;
      req_bus.operation = '0;
      req_bus.position  = '0;
      req_bus.value     = '0;
      rsp_bus.ready     = 1'b0;

      // directed: empty list cases first
      plan_request(OP_READ, 0, '0);
      plan_request(OP_REMOVE_LAST, 0, '0);
      plan_request(OP_REMOVE_AT, 5, '0);
      plan_request(SPARE_OP_LO, '1, '1);
      // build a short list with extreme handles
      plan_request(OP_APPEND, 0, '0);
      plan_request(OP_APPEND, '1, '1);
      plan_request(OP_INSERT, 0, 32'h5a5a_5a5a);
      plan_request(OP_INSERT, '1, 32'h1234_5678);    // past the end, so appended
      plan_request(OP_INSERT, 2, 32'h8000_0001);
      // reads inside and past the end
      plan_request(OP_READ, 0, '0);
      plan_request(OP_READ, 4, '0);
      plan_request(OP_READ, 5, '0);
      plan_request(OP_READ, '1, '0);
      // removals in the middle, past the end, at the tail and at the head; spare codes
      plan_request(OP_REMOVE_AT, 2, '0);
      plan_request(OP_REMOVE_AT, '1, '0);
      plan_request(OP_REMOVE_LAST, 0, '1);
      plan_request(3'(SPARE_OP_LO + 1), 0, '0);
      plan_request(SPARE_OP_HI, '1, '1);
      plan_request(OP_REMOVE_AT, 0, '0);
      plan_request(OP_REMOVE_AT, 0, '0);
      plan_request(OP_READ, 0, '0);

      // random: swing between filling to full and draining to empty
      growing = 1'b1;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (plan_len == DEPTH && $urandom_range(7) == 0)
            growing = 1'b0;
         else if (plan_len == 0 && $urandom_range(3) == 0)
            growing = 1'b1;
         roll = $urandom_range(99);
         coin = $urandom_range(1);
         if (roll < 5)
            op = OP_W'($urandom_range(SPARE_OP_HI, SPARE_OP_LO));
         else if (roll < 20)
            op = OP_READ;
         else if ((roll < 75) == growing)
            op = coin ? OP_INSERT : OP_APPEND;
         else
            op = coin ? OP_REMOVE_AT : OP_REMOVE_LAST;
         // half the positions land inside the list, the rest anywhere
         if ($urandom_range(1) == 1 && plan_len > 0)
            pos = POS_W'($urandom_range(plan_len - 1));
         else
            pos = POS_W'($urandom_range((1 << POS_W) - 1));
         case ($urandom_range(15))
            0:       val = '0;
            1:       val = '1;
            default: val = $urandom();
         endcase
         plan_request(op, pos, val);
      end

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // all beats accepted, all responses in, then a quiet tail for strays
      while (requests_taken != total_requests)
         @(posedge clock);
      while (expected_answers.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

/* filelist.f */
src/ple_pkg.sv
src/ple_req_if.sv
src/ple_rsp_if.sv
src/ple_ctrl.sv
src/ple_datapath.sv
src/positional_list_engine.sv
test/positional_list_engine_test.sv
